@@ rtl/core/cpcs_pkg.sv @@
// Shared constants and types for the circle point count store.
// No dependencies; imported by every module of the block.
`default_nettype none

package cpcs_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int COORD_BITS_DEF = 16;
    localparam int RADIUS_W       = 15;
    localparam int COUNT_W        = 11;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // status from the distance pipeline back to the controller
    typedef struct packed {
        logic hit;   // a point inside the circle leaves the last stage
        logic busy;  // some stage still holds a point
    } t_pipe_stat;

endpackage

`default_nettype wire

@@ rtl/core/cpcs_point_mem.sv @@
// Point memory: one write port, one read port, registered read data.
// Uses cpcs_pkg for its parameter defaults and the common import convention.
`default_nettype none

module cpcs_point_mem #(
    parameter int DEPTH  = cpcs_pkg::MAX_POINTS_DEF,
    parameter int AW     = $clog2(DEPTH),
    parameter int DATA_W = 2 * cpcs_pkg::COORD_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic                   o_rvalid,
    output logic [DATA_W-1:0]      o_rdata
);
    import cpcs_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;
    logic              r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= 1'b0;
        end else begin
            r_rvalid <= i_re;
        end
    end

    assign o_rvalid = r_rvalid;
    assign o_rdata  = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/cpcs_dist_pipe.sv @@
// Three-stage circle test on one stored point per cycle:
// abs difference and box check, squares, sum compare. Uses cpcs_pkg.
`default_nettype none

module cpcs_dist_pipe #(
    parameter int COORD_BITS = cpcs_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_pt_valid,
    input  wire logic [2*COORD_BITS-1:0]           i_pt_data,
    input  wire logic signed [COORD_BITS-1:0]      i_cx,
    input  wire logic signed [COORD_BITS-1:0]      i_cy,
    input  wire logic [cpcs_pkg::RADIUS_W-1:0]     i_radius,
    output cpcs_pkg::t_pipe_stat                   o_stat
);
    import cpcs_pkg::*;

    // difference width, never narrower than radius plus one
    localparam int DW = (COORD_BITS + 1 > RADIUS_W + 1) ? COORD_BITS + 1 : RADIUS_W + 1;
    localparam int SW = 2 * RADIUS_W;

    logic signed [COORD_BITS-1:0] pt_x, pt_y;
    logic signed [DW-1:0]         dx, dy;
    logic        [DW-1:0]         ax, ay;
    logic                         near;

    logic                r_v1, r_v2, r_v3;
    logic                r_near1, r_near2, r_hit3;
    logic [RADIUS_W-1:0] r_ax1, r_ay1;
    logic [SW-1:0]       r_sqx2, r_sqy2, r_rr2;
    logic [SW:0]         sum;

    assign pt_x = i_pt_data[2*COORD_BITS-1:COORD_BITS];
    assign pt_y = i_pt_data[COORD_BITS-1:0];

    always_comb begin
        dx   = DW'(pt_x) - DW'(i_cx);
        dy   = DW'(pt_y) - DW'(i_cy);
        ax   = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay   = dy[DW-1] ? DW'(-dy) : DW'(dy);
        near = (ax <= DW'(i_radius)) && (ay <= DW'(i_radius));
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_ax1   <= ax[RADIUS_W-1:0];
        r_ay1   <= ay[RADIUS_W-1:0];
        r_near1 <= near;
        r_sqx2  <= r_ax1 * r_ax1;
        r_sqy2  <= r_ay1 * r_ay1;
        r_rr2   <= i_radius * i_radius;
        r_near2 <= r_near1;
        r_hit3  <= r_near2 && (sum <= {1'b0, r_rr2});
    end

    assign sum = {1'b0, r_sqx2} + {1'b0, r_sqy2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_pt_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_stat.hit  = r_v3 && r_hit3;
    assign o_stat.busy = r_v1 || r_v2 || r_v3;

endmodule

`default_nettype wire

@@ rtl/core/circle_point_count_store_core.sv @@
// Top level: point store with circular range count queries.
// Depends on cpcs_pkg, cpcs_point_mem and cpcs_dist_pipe.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+-----------------------------------------
//  item in  | input     | i_valid, o_stall | i_kind, i_point_x, i_point_y, i_radius
//  result   | output    | o_valid, i_stall | o_inside_count, o_dropped
//
// One item is in work at a time; o_stall is low only while the controller is idle.
// Add: the memory write happens on the accept edge; the result goes through ST_FIN into the output register.
// Query: one memory read per stored point, through the single read port of the point memory,
// and each point read goes through the three-stage distance test.
// The output register lets the next item be taken while a result waits under i_stall.
// Synchronous active-low reset empties the store; memory contents need no clearing.
`default_nettype none

module circle_point_count_store_core #(
    parameter int MAX_POINTS = cpcs_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = cpcs_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_kind,
    input  wire logic signed [COORD_BITS-1:0]        i_point_x,
    input  wire logic signed [COORD_BITS-1:0]        i_point_y,
    input  wire logic [cpcs_pkg::RADIUS_W-1:0]       i_radius,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [cpcs_pkg::COUNT_W-1:0]             o_inside_count,
    output logic                                     o_dropped
);
    import cpcs_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]                r_total, n_total;
    logic [CW-1:0]                r_rd_addr, n_rd_addr;
    logic [CW-1:0]                r_count, n_count;
    logic                         r_drop, n_drop;
    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic [RADIUS_W-1:0]          r_radius;
    logic                         r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]           r_out_count, n_out_count;
    logic                         r_out_drop, n_out_drop;

    logic                         accept;
    logic                         full;
    logic                         mem_we;
    logic                         mem_re;
    logic                         mem_rvalid;
    logic [2*COORD_BITS-1:0]      mem_rdata;
    logic                         out_free;
    logic [CW+COUNT_W-1:0]        count_ext;
    t_pipe_stat                   pipe_stat;

    assign accept    = i_valid && !o_stall;
    assign full      = (r_total == CW'(MAX_POINTS));
    assign mem_we    = accept && (i_kind == KIND_ADD) && !full;
    assign mem_re    = (r_state == ST_SCAN);
    assign out_free  = !r_out_valid || !i_stall;
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    cpcs_point_mem #(
        .DEPTH  (MAX_POINTS),
        .AW     (AW),
        .DATA_W (2 * COORD_BITS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (mem_we),
        .i_waddr  (r_total[AW-1:0]),
        .i_wdata  ({i_point_x, i_point_y}),
        .i_re     (mem_re),
        .i_raddr  (r_rd_addr[AW-1:0]),
        .o_rvalid (mem_rvalid),
        .o_rdata  (mem_rdata)
    );

    cpcs_dist_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pt_valid (mem_rvalid),
        .i_pt_data  (mem_rdata),
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_radius   (r_radius),
        .o_stat     (pipe_stat)
    );

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_rd_addr   = r_rd_addr;
        n_count     = r_count;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_drop  = r_out_drop;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (pipe_stat.hit) begin
            n_count = r_count + CW'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_count   = '0;
                    n_rd_addr = '0;
                    n_drop    = 1'b0;
                    if (i_kind == KIND_ADD) begin
                        if (full) begin
                            n_drop = 1'b1;
                        end else begin
                            n_total = r_total + CW'(1);
                        end
                        n_state = ST_FIN;
                    end else if (r_total == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                n_rd_addr = r_rd_addr + CW'(1);
                if (n_rd_addr == r_total) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mem_rvalid && !pipe_stat.busy) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = count_ext[COUNT_W-1:0];
                    n_out_drop  = r_drop;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_rd_addr   <= '0;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_rd_addr   <= n_rd_addr;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // query parameters and output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cx     <= i_point_x;
            r_cy     <= i_point_y;
            r_radius <= i_radius;
        end
        r_out_count <= n_out_count;
        r_out_drop  <= n_out_drop;
    end

    assign o_stall        = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_inside_count = r_out_count;
    assign o_dropped      = r_out_drop;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CW'(MAX_POINTS))
        else $error("stored total beyond capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_total)
        else $error("count exceeds stored points");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_rd_addr < r_total))
        else $error("read beyond written entries");

    a_drop_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_inside_count == '0))
        else $error("dropped add with nonzero count");

    a_no_hit_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_FIN) |-> !pipe_stat.busy)
        else $error("distance pipeline active outside a query");
`endif

endmodule

`default_nettype wire

@@ verif/tb_circle_point_count_store_core.sv @@
// Testbench for circle_point_count_store_core: directed and random add/query traffic.
// Depends on cpcs_pkg and the core RTL; results are checked against an in-bench predictor.
`default_nettype none

module tb_circle_point_count_store_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cpcs_pkg::*;

    localparam int CAP             = MAX_POINTS_DEF;
    localparam int COORD_W         = COORD_BITS_DEF;
    localparam int RADIUS_MAX      = (1 << RADIUS_W) - 1;
    localparam int RANDOM_ITEMS    = 580;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 20000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int MAX_REPORTS     = 10;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [RADIUS_W-1:0]       radius_t;

    typedef struct packed {
        logic [COUNT_W-1:0] inside_count;
        logic               dropped;
    } circle_result_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic    i_clk;
    logic    i_rst_n        = 1'b0;
    logic    i_valid        = 1'b0;
    logic    i_kind         = KIND_ADD;
    coord_t  i_point_x      = '0;
    coord_t  i_point_y      = '0;
    radius_t i_radius       = '0;
    logic    i_stall        = 1'b0;
    logic    o_stall;
    logic    o_valid;
    logic [COUNT_W-1:0] o_inside_count;
    logic    o_dropped;

    // predictor state: a flat copy of the point store
    coord_t  store_x [CAP];
    coord_t  store_y [CAP];
    int      stored_count = 0;

    circle_result_t expected_results[$];
    int      fail_count    = 0;
    int      quiet_cycles  = 0;
    int      burst_left    = 0;
    bit      hold_off_req  = 1'b0;
    coord_t  cluster_x [4];
    coord_t  cluster_y [4];

    circle_point_count_store_core #(
        .MAX_POINTS (CAP),
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_radius       (i_radius),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_inside_count (o_inside_count),
        .o_dropped      (o_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Applies one item to the predicted store and returns the result it should give.
    function automatic circle_result_t predict_circle_count(input logic kind, input coord_t cx,
                                                            input coord_t cy, input radius_t r);
        circle_result_t res;
        longint dx, dy, rr;
        int hits;
        int i;
        res  = '0;
        hits = 0;
        rr   = longint'(r);
        if (kind == KIND_ADD) begin
            if (stored_count < CAP) begin
                store_x[stored_count] = cx;
                store_y[stored_count] = cy;
                stored_count++;
            end else begin
                res.dropped = 1'b1;
            end
        end else begin
            for (i = 0; i < stored_count; i++) begin
                dx = longint'(store_x[i]) - longint'(cx);
                dy = longint'(store_y[i]) - longint'(cy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                if (dx <= rr && dy <= rr && dx * dx + dy * dy <= rr * rr)
                    hits++;
            end
            res.inside_count = hits[COUNT_W-1:0];
        end
        return res;
    endfunction

    function automatic coord_t near(input coord_t c, input int spread);
        return coord_t'(int'(c) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic radius_t rand_radius();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return radius_t'(RADIUS_MAX);
            2, 3:    return radius_t'($urandom_range(1, 64));
            4, 5, 6: return radius_t'($urandom_range(64, 2048));
            7, 8:    return radius_t'($urandom_range(2048, 16384));
            default: return radius_t'($urandom);
        endcase
    endfunction

    // Sends one transaction in bursts with random gaps; records the prediction on accept.
    task automatic send_item(input logic kind, input coord_t x, input coord_t y,
                             input radius_t r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
        end
        i_kind    <= kind;
        i_point_x <= x;
        i_point_y <= y;
        i_radius  <= r;
        i_valid   <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_results.push_back(predict_circle_count(kind, x, y, r));
        burst_left--;
    endtask

    task automatic send_add(input coord_t x, input coord_t y);
        send_item(KIND_ADD, x, y, radius_t'($urandom));
    endtask

    task automatic send_query(input coord_t x, input coord_t y, input radius_t r);
        send_item(KIND_QUERY, x, y, r);
    endtask

    // random query: near a cluster, anywhere, or exactly on the rim through a stored point
    task automatic send_random_query();
        int a, b, c, k, j, sel, pick;
        int tri_a[3] = '{3, 5, 8};
        int tri_b[3] = '{4, 12, 15};
        int tri_c[3] = '{5, 13, 17};
        pick = $urandom_range(0, 3);
        sel  = $urandom_range(0, 9);
        if (sel < 3 && stored_count > 0) begin
            j = $urandom_range(0, 2);
            k = $urandom_range(1, RADIUS_MAX / tri_c[j]);
            a = ($urandom_range(0, 1) != 0) ? tri_a[j] * k : -tri_a[j] * k;
            b = ($urandom_range(0, 1) != 0) ? tri_b[j] * k : -tri_b[j] * k;
            c = tri_c[j] * k;
            j = $urandom_range(0, stored_count - 1);
            send_query(coord_t'(int'(store_x[j]) + a), coord_t'(int'(store_y[j]) + b),
                       radius_t'(c));
        end else if (sel < 8) begin
            send_query(near(cluster_x[pick], 300), near(cluster_y[pick], 300), rand_radius());
        end else begin
            send_query(coord_t'($urandom), coord_t'($urandom), rand_radius());
        end
    endtask

    task automatic send_random_add();
        int pick;
        pick = $urandom_range(0, 3);
        if ($urandom_range(0, 9) < 6)
            send_add(near(cluster_x[pick], $urandom_range(4, 400)),
                     near(cluster_y[pick], $urandom_range(4, 400)));
        else
            send_add(coord_t'($urandom), coord_t'($urandom));
    endtask

    task automatic test_empty_store();
        send_query('0, '0, '0);
        send_query(coord_t'(-32768), coord_t'(32767), radius_t'(RADIUS_MAX));
    endtask

    // extreme coordinates, a point on the rim, and radius ignored on adds
    task automatic test_extreme_points();
        send_item(KIND_ADD, '0, '0, radius_t'(RADIUS_MAX));
        send_item(KIND_ADD, coord_t'(3), coord_t'(4), radius_t'('h5555));
        send_item(KIND_ADD, coord_t'(-32768), coord_t'(-32768), radius_t'('h2AAA));
        send_add(coord_t'(32767), coord_t'(32767));
        send_add(coord_t'(32767), coord_t'(-32768));
        send_add(coord_t'(-32768), coord_t'(32767));
        send_add('0, coord_t'(32767));
        send_add(coord_t'(-1), coord_t'(-1));
        send_query('0, '0, radius_t'(5));
        send_query('0, '0, radius_t'(4));
        send_query(coord_t'(3), coord_t'(4), '0);
        send_query('0, '0, radius_t'(RADIUS_MAX));
        send_query(coord_t'(-32768), coord_t'(-32768), radius_t'(RADIUS_MAX));
        send_query(coord_t'(32767), coord_t'(32767), radius_t'(RADIUS_MAX));
        send_query(coord_t'(32767), '0, radius_t'(RADIUS_MAX));
        send_query(coord_t'(-32768), '0, '0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        int n;
        hold_off_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            if ($urandom_range(0, 3) == 0)
                send_query(near('0, 50), near('0, 50), radius_t'($urandom_range(0, 200)));
            else
                send_add(near('0, 100), near('0, 100));
        end
    endtask

    task automatic test_random_mix();
        int n;
        for (n = 0; n < 4; n++) begin
            cluster_x[n] = coord_t'($urandom);
            cluster_y[n] = coord_t'($urandom);
        end
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 45)
                send_random_add();
            else
                send_random_query();
        end
    endtask

    // fill to capacity, then adds are dropped while queries still count the full store
    task automatic test_full_store();
        int n;
        while (stored_count < CAP) begin
            send_random_add();
            if (stored_count % 200 == 0)
                send_random_query();
        end
        send_query('0, '0, radius_t'(RADIUS_MAX));
        for (n = 0; n < 4; n++) begin
            send_random_add();
            send_random_query();
        end
        send_add(coord_t'(-32768), coord_t'(32767));
        send_query(cluster_x[0], cluster_y[0], radius_t'(RADIUS_MAX));
    endtask

    // receiver stall pattern, plus the one long hold-off on request
    initial begin
        stall_mode_t mode;
        int left;
        int phase;
        mode  = STALL_NONE;
        left  = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (left == 0) begin
                mode = stall_mode_t'($urandom_range(0, 3));
                left = $urandom_range(64, 256);
            end
            left--;
            phase++;
            case (mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 7);
                default:     i_stall <= ((phase % 7) < 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        circle_result_t got;
        circle_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.inside_count = o_inside_count;
            got.dropped      = o_dropped;
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: count=%0d dropped=%0b",
                             got.inside_count, got.dropped);
            end else begin
                want = expected_results.pop_front();
                if (got.inside_count !== want.inside_count || got.dropped !== want.dropped) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch: expected count=%0d dropped=%0b, got count=%0d dropped=%0b",
                                 want.inside_count, want.dropped,
                                 got.inside_count, got.dropped);
                end
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_circle_point_count_store_core: FAIL");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_store();
        test_extreme_points();
        test_output_backpressure();
        test_random_mix();
        test_full_store();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_circle_point_count_store_core: PASS");
        else
            $display("tb_circle_point_count_store_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ circle_point_count_store_core.f @@
rtl/core/cpcs_pkg.sv
rtl/core/cpcs_point_mem.sv
rtl/core/cpcs_dist_pipe.sv
rtl/core/circle_point_count_store_core.sv
verif/tb_circle_point_count_store_core.sv
